// ===== hdl/modd_pkg.sv =====
`default_nettype none

package modd_pkg;

    localparam int MAX_MISMATCHES = 16;

    localparam int SYM_W      = 16;
    localparam int OFF_W      = 16;
    localparam int SLOT_W     = 4;
    localparam int CNT_CFG_W  = 5;
    localparam int RLEN_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [RLEN_W-1:0] RLEN_RESET = 16'd128;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_LENGTH    = 2'd1;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
    } t_sym_item;

    typedef struct packed {
        logic [OFF_W-1:0]  offset;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_off_item;

    // offset write from the record decoder into the bank buffer
    typedef struct packed {
        logic             we;
        logic             done;
        logic [OFF_W-1:0] value;
    } t_wr_req;

endpackage

`default_nettype wire

// ===== hdl/modd_sym_if.sv =====
`default_nettype none

interface modd_sym_if;
    logic                 valid;
    logic                 ready;
    modd_pkg::t_sym_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/modd_off_if.sv =====
`default_nettype none

interface modd_off_if;
    logic                 valid;
    logic                 ready;
    modd_pkg::t_off_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/modd_fill.sv =====
`default_nettype none

module modd_fill #(
    parameter int  MAX_MISMATCHES = modd_pkg::MAX_MISMATCHES,
    localparam int CNT_W = $clog2(MAX_MISMATCHES + 1),
    localparam int PH_W  = $clog2(MAX_MISMATCHES + 2),
    localparam int IDX_W = (MAX_MISMATCHES > 1) ? $clog2(MAX_MISMATCHES) : 1
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    input  wire logic [modd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [modd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_accept,
    input  wire logic [modd_pkg::SYM_W-1:0]      i_symbol,
    output modd_pkg::t_wr_req                    o_wr,
    output logic [IDX_W-1:0]                     o_wr_idx,
    output logic [CNT_W-1:0]                     o_count
);

    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic [PH_W-1:0]               r_last_phase, n_last_phase;
    logic                          r_big, n_big;
    logic [modd_pkg::RLEN_W-1:0]   r_rlen;
    logic [PH_W-1:0]               r_phase;
    logic                          r_reverse;
    logic [modd_pkg::SYM_W-1:0]    r_min_gap;
    logic [modd_pkg::OFF_W-1:0]    r_run;

    logic [modd_pkg::CNT_CFG_W-1:0] w_cnt_raw;
    logic [31:0]                    w_cnt_wide;
    logic [modd_pkg::OFF_W-1:0]     w_delta;
    logic [PH_W-1:0]                w_g;
    logic [PH_W-1:0]                w_gsel;
    logic [PH_W-1:0]                w_slot_wide;
    logic                           w_flag_ph;
    logic                           w_anchor_ph;
    logic                           w_mingap_ph;
    logic                           w_done;
    logic [modd_pkg::OFF_W-1:0]     w_value;

    // saturated count and derived record length for a config write
    always_comb begin
        w_cnt_raw  = i_cfg_data[modd_pkg::CNT_CFG_W-1:0];
        w_cnt_wide = 32'(w_cnt_raw);
        if (w_cnt_raw == '0) begin
            n_cnt = CNT_W'(1);
        end else if (w_cnt_wide > 32'(MAX_MISMATCHES)) begin
            n_cnt = CNT_W'(MAX_MISMATCHES);
        end else begin
            n_cnt = CNT_W'(w_cnt_wide);
        end
        n_big = (32'(n_cnt) > 32'd2);
        if (32'(n_cnt) == 32'd1) begin
            n_last_phase = PH_W'(1);
        end else if (32'(n_cnt) == 32'd2) begin
            n_last_phase = PH_W'(2);
        end else begin
            n_last_phase = PH_W'(n_cnt) + PH_W'(1);
        end
    end

    always_comb begin
        w_flag_ph   = (r_phase == '0);
        w_anchor_ph = (r_phase == PH_W'(1));
        w_mingap_ph = (r_phase == PH_W'(2)) && r_big;
        w_done      = i_accept && (r_phase >= r_last_phase);

        w_delta = i_symbol + (r_big ? r_min_gap : modd_pkg::SYM_W'(1));
        w_g     = r_phase - (r_big ? PH_W'(2) : PH_W'(1));
        w_gsel  = w_anchor_ph ? '0 : w_g;
        // reverse records fill from the top slot downward
        w_slot_wide = r_reverse ? (PH_W'(r_cnt) - PH_W'(1) - w_gsel) : w_gsel;

        if (w_anchor_ph) begin
            w_value = r_reverse ? (r_rlen - 16'd1 - i_symbol) : i_symbol;
        end else begin
            w_value = r_reverse ? (r_run - w_delta) : (r_run + w_delta);
        end

        o_wr.we    = i_accept && !w_flag_ph && !w_mingap_ph;
        o_wr.done  = w_done;
        o_wr.value = w_value;
        o_wr_idx   = w_slot_wide[IDX_W-1:0];
        o_count    = r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt        <= CNT_W'(1);
            r_last_phase <= PH_W'(1);
            r_big        <= 1'b0;
            r_rlen       <= modd_pkg::RLEN_RESET;
            r_phase      <= '0;
            r_reverse    <= 1'b0;
            r_min_gap    <= modd_pkg::SYM_W'(1);
            r_run        <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                modd_pkg::CFG_MISMATCH_COUNT: begin
                    r_cnt        <= n_cnt;
                    r_last_phase <= n_last_phase;
                    r_big        <= n_big;
                    r_phase      <= '0;
                end
                modd_pkg::CFG_READ_LENGTH: begin
                    r_rlen <= i_cfg_data[modd_pkg::RLEN_W-1:0];
                end
                default: begin
                end
            endcase
        end else if (i_accept) begin
            if (w_flag_ph) begin
                r_reverse <= (i_symbol != '0);
            end else if (w_mingap_ph) begin
                r_min_gap <= i_symbol + modd_pkg::SYM_W'(1);
            end else begin
                r_run <= w_value;
            end
            r_phase <= w_done ? '0 : (r_phase + PH_W'(1));
        end
    end

endmodule

`default_nettype wire

// ===== hdl/modd_bank.sv =====
`default_nettype none

module modd_bank #(
    parameter int  MAX_MISMATCHES = modd_pkg::MAX_MISMATCHES,
    localparam int CNT_W  = $clog2(MAX_MISMATCHES + 1),
    localparam int IDX_W  = (MAX_MISMATCHES > 1) ? $clog2(MAX_MISMATCHES) : 1,
    localparam int ADDR_W = IDX_W + 1,
    localparam int DEPTH  = 2 * MAX_MISMATCHES
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire modd_pkg::t_wr_req i_wr,
    input  wire logic [IDX_W-1:0]  i_wr_idx,
    input  wire logic [CNT_W-1:0]  i_count,
    output logic                   o_fill_ready,
    output logic                   o_idle,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output modd_pkg::t_off_item    o_out_item
);

    logic [modd_pkg::OFF_W-1:0]  r_mem [DEPTH];

    logic [1:0]                  r_full;
    logic                        r_fill_bank;
    logic                        r_drain_bank;
    logic [IDX_W-1:0]            r_rd_idx;
    logic                        r_out_valid;
    logic [modd_pkg::OFF_W-1:0]  r_out_offset;
    logic [modd_pkg::SLOT_W-1:0] r_out_slot;
    logic                        r_out_last;

    logic                        w_issue;
    logic                        w_rd_last;
    logic [IDX_W+modd_pkg::SLOT_W-1:0] w_idx_ext;
    logic [ADDR_W-1:0]           w_waddr;
    logic [ADDR_W-1:0]           w_raddr;

    always_comb begin
        w_issue   = r_full[r_drain_bank] && (!r_out_valid || i_out_ready);
        w_rd_last = (32'(r_rd_idx) == (32'(i_count) - 32'd1));
        w_idx_ext = {{modd_pkg::SLOT_W{1'b0}}, r_rd_idx};
        w_waddr   = {r_fill_bank, i_wr_idx};
        w_raddr   = {r_drain_bank, r_rd_idx};
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[w_waddr] <= i_wr.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_out_offset <= r_mem[w_raddr];
            r_out_slot   <= w_idx_ext[modd_pkg::SLOT_W-1:0];
            r_out_last   <= w_rd_last;
        end
    end

    // fill and drain alternate between the two banks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full       <= '0;
            r_fill_bank  <= 1'b0;
            r_drain_bank <= 1'b0;
            r_rd_idx     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_wr.done) begin
                r_full[r_fill_bank] <= 1'b1;
                r_fill_bank         <= ~r_fill_bank;
            end
            if (w_issue) begin
                r_out_valid <= 1'b1;
                if (w_rd_last) begin
                    r_full[r_drain_bank] <= 1'b0;
                    r_drain_bank         <= ~r_drain_bank;
                    r_rd_idx             <= '0;
                end else begin
                    r_rd_idx <= r_rd_idx + IDX_W'(1);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_fill_ready      = !r_full[r_fill_bank];
        // no record waiting and no offset on the output
        o_idle            = (r_full == 2'b00) && !r_out_valid;
        o_out_valid       = r_out_valid;
        o_out_item.offset = r_out_offset;
        o_out_item.slot   = r_out_slot;
        o_out_item.last   = r_out_last;
    end

endmodule

`default_nettype wire

// ===== hdl/mismatch_offset_delta_decoder.sv =====
// The first offset of a record enters the registered read port after its bank is
//   marked full; the rest follow in slot order while the sink is ready.
// Throughput: one symbol per cycle while the fill bank is free; one offset per cycle
//   when the sink is ready. Two banks let one record drain while the next fills.
// Reset (synchronous, active low) clears record state, bank flags and output valid;
//   config goes to count 1, read length 128. Buffer contents are not cleared.
`default_nettype none

module mismatch_offset_delta_decoder #(
    parameter int MAX_MISMATCHES = modd_pkg::MAX_MISMATCHES
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    modd_sym_if.sink                             i_sym,
    modd_off_if.source                           o_off,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [modd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [modd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_MISMATCHES + 1);
    localparam int IDX_W = (MAX_MISMATCHES > 1) ? $clog2(MAX_MISMATCHES) : 1;

    modd_pkg::t_wr_req  w_wr;
    logic [IDX_W-1:0]   w_wr_idx;
    logic [CNT_W-1:0]   w_count;
    logic               w_fill_ready;
    logic               w_drain_idle;
    logic               w_cfg_write;
    logic               w_accept;

    // config transactions wait until every buffered offset has drained, so the
    // count seen by the drain side never changes under a pending record
    assign o_cfg_ready = w_drain_idle;
    assign w_cfg_write = i_cfg_valid && w_drain_idle;

    // a symbol is taken whenever the bank being filled is free, except in the
    // cycle of a config write
    assign i_sym.ready = w_fill_ready && !w_cfg_write;
    assign w_accept    = i_sym.valid && w_fill_ready && !w_cfg_write;

    // record decoder: flag, anchor, min gap and gap steps, one add path per symbol
    modd_fill #(
        .MAX_MISMATCHES (MAX_MISMATCHES)
    ) u_fill (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (w_cfg_write),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_accept),
        .i_symbol    (i_sym.data.symbol),
        .o_wr        (w_wr),
        .o_wr_idx    (w_wr_idx),
        .o_count     (w_count)
    );

    // ping-pong offset buffer, drained in ascending slot order
    modd_bank #(
        .MAX_MISMATCHES (MAX_MISMATCHES)
    ) u_bank (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (w_wr),
        .i_wr_idx     (w_wr_idx),
        .i_count      (w_count),
        .o_fill_ready (w_fill_ready),
        .o_idle       (w_drain_idle),
        .i_out_ready  (o_off.ready),
        .o_out_valid  (o_off.valid),
        .o_out_item   (o_off.data)
    );

endmodule

`default_nettype wire

// ===== hdl/modd_checker.sv =====
`default_nettype none

module modd_checker #(
    parameter int MAX_MISMATCHES = modd_pkg::MAX_MISMATCHES
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [modd_pkg::OFF_W-1:0]   i_offset,
    input wire logic [modd_pkg::SLOT_W-1:0]  i_slot,
    input wire logic                         i_last
);

    logic [modd_pkg::SLOT_W-1:0] r_exp_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_slot <= '0;
        end else if (i_out_valid && i_out_ready) begin
            r_exp_slot <= i_last ? '0 : (i_slot + modd_pkg::SLOT_W'(1));
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_offset) && $stable(i_slot) && $stable(i_last))
        else $error("stalled offset changed");

    a_slot_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_slot == r_exp_slot))
        else $error("offset slot out of sequence");

    a_top_slot_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (MAX_MISMATCHES <= 16)
            && (32'(i_slot) == 32'(MAX_MISMATCHES - 1)) |-> i_last)
        else $error("top slot without last");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind mismatch_offset_delta_decoder modd_checker #(
    .MAX_MISMATCHES (MAX_MISMATCHES)
) u_modd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_off.valid),
    .i_out_ready (o_off.ready),
    .i_offset    (o_off.data.offset),
    .i_slot      (o_off.data.slot),
    .i_last      (o_off.data.last)
);

`default_nettype wire

// ===== tb/tb_mismatch_offset_delta_decoder.sv =====
`default_nettype none

// Drives decoded record symbols into the mismatch offset decoder, tracks its
// behavior with an in-bench offset predictor and compares every offset
// transaction field by field, in order.
module tb_mismatch_offset_delta_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import modd_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 2;
    localparam int RANDOM_SYMBOLS = 130;
    localparam int SETTLE_CYCLES  = 4;      // wait for the block to go quiet after its last offset
    localparam int DRAIN_CYCLES   = 20;
    localparam int LIMIT_CYCLES   = 250_000;
    localparam int REPORT_MAX     = 10;

    // config indexes past the two registers; the block must ignore them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef enum logic {ROW_SYM, ROW_CFG} t_row_kind;

    // index only matters for config rows; want_offset only when typed is set
    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   index;
        logic [CFG_DATA_W-1:0]  value;
        bit                     typed;
        logic [OFF_W-1:0]       want_offset;
    } t_plan_row;

    localparam int PLAN_ROWS = 31;

    // Directed opener. Single-offset records carry their answer inline;
    // the multi-offset ones go through the predictor.
    t_plan_row plan [PLAN_ROWS] = '{
        // reset settings: count 1, read length 128
        '{ROW_SYM, CFG_MISMATCH_COUNT, 16'h0000, 1'b0, 16'h0000},   // forward flag
        '{ROW_SYM, CFG_MISMATCH_COUNT, 16'h0000, 1'b1, 16'h0000},   // anchor 0
        '{ROW_SYM, CFG_MISMATCH_COUNT, 16'h0001, 1'b0, 16'h0000},   // reverse flag
        '{ROW_SYM, CFG_MISMATCH_COUNT, 16'h0000, 1'b1, 16'd127},    // 128 - 1 - 0
        '{ROW_SYM, CFG_MISMATCH_COUNT, 16'hFFFF, 1'b0, 16'h0000},   // all-ones flag is reverse
        '{ROW_SYM, CFG_MISMATCH_COUNT, 16'd127,  1'b1, 16'h0000},   // lands on zero
        '{ROW_SYM, CFG_MISMATCH_COUNT, 16'h8000, 1'b0, 16'h0000},   // top bit only: reverse
        '{ROW_SYM, CFG_MISMATCH_COUNT, 16'd200,  1'b1, 16'hFFB7},   // anchor past read end wraps
        // two offsets per record, step is gap + 1
        '{ROW_CFG, CFG_MISMATCH_COUNT, 16'd2,    1'b0, 16'h0000},
        '{ROW_SYM, CFG_MISMATCH_COUNT, 16'h0000, 1'b0, 16'h0000},
        '{ROW_SYM, CFG_MISMATCH_COUNT, 16'hFFFF, 1'b0, 16'h0000},   // max anchor
        '{ROW_SYM, CFG_MISMATCH_COUNT, 16'h0000, 1'b0, 16'h0000},   // upward step wraps to 0
        '{ROW_SYM, CFG_MISMATCH_COUNT, 16'h5A5A, 1'b0, 16'h0000},
        '{ROW_SYM, CFG_MISMATCH_COUNT, 16'd10,   1'b0, 16'h0000},
        '{ROW_SYM, CFG_MISMATCH_COUNT, 16'hFFFF, 1'b0, 16'h0000},   // gap + 1 wraps to no step
        // three offsets: min gap present
        '{ROW_CFG, CFG_MISMATCH_COUNT, 16'd3,    1'b0, 16'h0000},
        '{ROW_SYM, CFG_MISMATCH_COUNT, 16'h0000, 1'b0, 16'h0000},
        '{ROW_SYM, CFG_MISMATCH_COUNT, 16'd5,    1'b0, 16'h0000},
        '{ROW_SYM, CFG_MISMATCH_COUNT, 16'hFFFF, 1'b0, 16'h0000},   // min gap 65535: step of 65536 wraps to zero
        '{ROW_SYM, CFG_MISMATCH_COUNT, 16'h0000, 1'b0, 16'h0000},
        '{ROW_SYM, CFG_MISMATCH_COUNT, 16'd3,    1'b0, 16'h0000},
        // count of zero acts as one
        '{ROW_CFG, CFG_MISMATCH_COUNT, 16'd0,    1'b0, 16'h0000},
        '{ROW_SYM, CFG_MISMATCH_COUNT, 16'h0000, 1'b0, 16'h0000},
        '{ROW_SYM, CFG_MISMATCH_COUNT, 16'd7,    1'b1, 16'd7},
        // zero read length, then a write to a missing register
        '{ROW_CFG, CFG_READ_LENGTH,    16'd0,    1'b0, 16'h0000},
        '{ROW_CFG, CFG_SPARE_2,        16'hFFFF, 1'b0, 16'h0000},
        '{ROW_SYM, CFG_MISMATCH_COUNT, 16'h0001, 1'b0, 16'h0000},
        '{ROW_SYM, CFG_MISMATCH_COUNT, 16'h0000, 1'b1, 16'hFFFF},   // 0 - 1 - 0
        // full read length
        '{ROW_CFG, CFG_READ_LENGTH,    16'hFFFF, 1'b0, 16'h0000},
        '{ROW_SYM, CFG_MISMATCH_COUNT, 16'h0002, 1'b0, 16'h0000},
        '{ROW_SYM, CFG_MISMATCH_COUNT, 16'hFFFF, 1'b1, 16'hFFFF}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    modd_sym_if sym_if ();
    modd_off_if off_if ();

    mismatch_offset_delta_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sym       (sym_if.sink),
        .o_off       (off_if.source),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Offset predictor: its own copy of the registers and record state
    // ---------------------------------------------------------------
    logic [CNT_CFG_W-1:0] cfg_count  = 5'd1;
    logic [RLEN_W-1:0]    cfg_rlen   = RLEN_RESET;
    logic [4:0]           rec_phase  = '0;          // 0 = waiting for the flag
    logic                 rev_mode   = 1'b0;
    logic [16:0]          min_step   = 17'd1;       // min gap value + 1, 17 bits wide
    logic [OFF_W-1:0]     pos_buf [MAX_MISMATCHES];
    logic [OFF_W-1:0]     run_pos    = '0;

    t_off_item expected_offsets [$];

    int mismatches    = 0;
    int sent_symbols  = 0;
    bit src_steady    = 1'b0;
    bit sink_steady   = 1'b0;
    int sink_hold     = 0;

    function automatic int count_in_use();
        if (cfg_count == 0) return 1;
        if (int'(cfg_count) > MAX_MISMATCHES) return MAX_MISMATCHES;
        return int'(cfg_count);
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap(input bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    function automatic logic [CNT_CFG_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 19);
        if (r < 8)  return CNT_CFG_W'($urandom_range(1, 3));
        if (r < 15) return CNT_CFG_W'($urandom_range(4, 15));
        if (r < 17) return CNT_CFG_W'(MAX_MISMATCHES);
        if (r < 18) return '0;
        return CNT_CFG_W'($urandom_range(17, 31));     // saturates
    endfunction

    function automatic logic [RLEN_W-1:0] pick_rlen();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'd1;
        if (r == 1) return 16'hFFFF;
        if (r == 2) return 16'd0;
        if (r < 5)  return RLEN_W'($urandom);
        return RLEN_W'($urandom_range(16, 400));
    endfunction

    task automatic store_pos(input int slot, input logic [OFF_W-1:0] v);
        pos_buf[slot] = v;
        run_pos       = v;
    endtask

    // Advance the predictor by one accepted symbol transaction; on the
    // record's closing symbol queue every buffered offset in slot order.
    task automatic decode_symbol(input logic [SYM_W-1:0] sym);
        int               cnt;
        int               last_ph;
        int               first_gap;
        int               g;
        logic [OFF_W-1:0] step;
        logic [OFF_W-1:0] delta;
        t_off_item        item;
        cnt       = count_in_use();
        last_ph   = (cnt == 1) ? 1 : ((cnt == 2) ? 2 : cnt + 1);
        first_gap = (cnt > 2) ? 3 : 2;

        if (rec_phase == 0) begin
            rev_mode = (sym != 0);
        end else if (rec_phase == 1) begin
            if (rev_mode) store_pos(cnt - 1, cfg_rlen - 16'd1 - sym);
            else          store_pos(0, sym);
        end else if (rec_phase == 2 && cnt > 2) begin
            min_step = {1'b0, sym} + 17'd1;
        end else begin
            g     = int'(rec_phase) - first_gap + 1;
            step  = (cnt > 2) ? min_step[15:0] : 16'd1;
            delta = sym + step;
            if (rev_mode) store_pos(cnt - 1 - g, run_pos - delta);
            else          store_pos(g, run_pos + delta);
        end

        if (int'(rec_phase) >= last_ph) begin
            rec_phase = '0;
            for (int k = 0; k < cnt; k++) begin
                item.offset = pos_buf[k];
                item.slot   = SLOT_W'(k);
                item.last   = (k == cnt - 1);
                expected_offsets = {expected_offsets, item};
            end
        end else begin
            rec_phase = rec_phase + 5'd1;
        end
    endtask

    // ---------------------------------------------------------------
    // Driving helpers (all called at a rising edge)
    // ---------------------------------------------------------------

    // Valid stays high across back-to-back transactions; it drops for a gap, with
    // junk on the bus while it is low, and while the bench waits for idle.
    task automatic send_symbol(input logic [SYM_W-1:0] v);
        int n;
        n = pick_gap(src_steady);
        cfg_valid <= 1'b0;
        if (n != 0) begin
            sym_if.valid       <= 1'b0;
            sym_if.data.symbol <= SYM_W'($urandom);
            repeat (n) @(posedge i_clk);
        end
        sym_if.valid       <= 1'b1;
        sym_if.data.symbol <= v;
        @(posedge i_clk);
        while (!sym_if.ready) @(posedge i_clk);
        decode_symbol(v);
        sent_symbols++;
    endtask

    // Leaves valid high so a following write can go back to back.
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        if (idx == CFG_MISMATCH_COUNT) begin
            cfg_count = d[CNT_CFG_W-1:0];
            rec_phase = '0;                 // partial record dropped
        end else if (idx == CFG_READ_LENGTH) begin
            cfg_rlen = d[RLEN_W-1:0];       // partial record kept
        end
    endtask

    // upper data bits are don't-care for the count register
    task automatic write_count(input logic [CNT_CFG_W-1:0] c);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'($urandom);
        d[CNT_CFG_W-1:0] = c;
        write_cfg(CFG_MISMATCH_COUNT, d);
    endtask

    // Quiesce: all offsets back, then a settle wait for a record still in flight.
    task automatic wait_idle();
        sym_if.valid <= 1'b0;
        cfg_valid    <= 1'b0;
        while (expected_offsets.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One well-formed record with random content. With mid_rlen set the read
    // length changes between flag and anchor, which the block must honor.
    task automatic send_record(input bit mid_rlen);
        int cnt;
        int r;
        cnt = count_in_use();
        send_symbol(($urandom_range(0, 1) == 0) ? 16'h0000 : SYM_W'($urandom_range(1, 65535)));
        if (mid_rlen) begin
            wait_idle();
            write_cfg(CFG_READ_LENGTH, pick_rlen());
        end
        if (cfg_rlen != 0 && $urandom_range(0, 9) < 7)
            send_symbol(SYM_W'($urandom_range(0, int'(cfg_rlen) - 1)));
        else
            send_symbol(SYM_W'($urandom));
        if (cnt > 2) begin
            r = $urandom_range(0, 9);
            if (r < 6)      send_symbol(SYM_W'($urandom_range(0, 3)));
            else if (r < 8) send_symbol(SYM_W'($urandom));
            else            send_symbol(16'hFFFF);
        end
        for (int k = 1; k < cnt; k++) begin
            if ($urandom_range(0, 9) < 7) send_symbol(SYM_W'($urandom_range(0, 7)));
            else                          send_symbol(SYM_W'($urandom));
        end
    endtask

    // ---------------------------------------------------------------
    // Offset sink: random backpressure, with calm stretches
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : sink_pace
        int n;
        if (sink_hold != 0) begin
            sink_hold    <= sink_hold - 1;
            off_if.ready <= 1'b0;
        end else begin
            n = pick_gap(sink_steady);
            off_if.ready <= (n == 0);
            sink_hold    <= (n == 0) ? 0 : n - 1;
        end
    end

    // ---------------------------------------------------------------
    // Checker: each offset transaction against the oldest expectation
    // ---------------------------------------------------------------
    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin : offset_check
        t_off_item want;
        if (i_rst_n && off_if.valid && off_if.ready) begin
            if (expected_offsets.size() == 0) begin
                flag_mismatch($sformatf("unexpected offset %0d slot %0d last %0d",
                              off_if.data.offset, off_if.data.slot, off_if.data.last));
            end else begin
                want = expected_offsets.pop_front();
                if (off_if.data.offset !== want.offset)
                    flag_mismatch($sformatf("offset expected %0d got %0d (slot %0d)",
                                  want.offset, off_if.data.offset, want.slot));
                if (off_if.data.slot !== want.slot)
                    flag_mismatch($sformatf("slot expected %0d got %0d",
                                  want.slot, off_if.data.slot));
                if (off_if.data.last !== want.last)
                    flag_mismatch($sformatf("last expected %0d got %0d (slot %0d)",
                                  want.last, off_if.data.last, want.slot));
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin : stimulus
        t_off_item             item;
        logic [CNT_CFG_W-1:0]  new_count;
        int                    start;
        int                    records;
        int                    r;
        int                    n;

        i_rst_n            <= 1'b0;
        cfg_valid          <= 1'b0;
        cfg_index          <= CFG_MISMATCH_COUNT;
        cfg_data           <= '0;
        sym_if.valid       <= 1'b0;
        sym_if.data.symbol <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed opener
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                wait_idle();
                write_cfg(plan[i].index, plan[i].value);
            end else begin
                send_symbol(plan[i].value);
                if (plan[i].typed) begin
                    item = expected_offsets[expected_offsets.size() - 1];
                    item.offset = plan[i].want_offset;
                    expected_offsets[expected_offsets.size() - 1] = item;
                end
            end
        end

        // Random phases: new settings at idle, then mostly well-formed
        // records with some torn ones and mid-record read length changes.
        start = sent_symbols;
        while (sent_symbols - start < RANDOM_SYMBOLS) begin
            wait_idle();
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            new_count   = pick_count();
            if ($urandom_range(0, 1) == 0) begin
                write_cfg(CFG_READ_LENGTH, pick_rlen());
                write_count(new_count);
            end else begin
                write_count(new_count);
                write_cfg(CFG_READ_LENGTH, pick_rlen());
            end
            if ($urandom_range(0, 4) == 0)
                write_cfg(($urandom_range(0, 1) == 0) ? CFG_SPARE_2 : CFG_SPARE_3,
                          CFG_DATA_W'($urandom));

            records = $urandom_range(1, 4);
            repeat (records) begin
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    // torn record, sometimes cut off by a count rewrite
                    n = $urandom_range(1, count_in_use() + 1);
                    repeat (n) send_symbol(SYM_W'($urandom));
                    if ($urandom_range(0, 1) == 0) begin
                        wait_idle();
                        write_count(cfg_count);
                    end
                end else begin
                    send_record(r == 1);
                end
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS mismatch_offset_delta_decoder");
        else
            $display("FAIL mismatch_offset_delta_decoder");
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("FAIL mismatch_offset_delta_decoder");
        $finish;
    end

endmodule

`default_nettype wire
